// ===== rtl/sbe_pkg.sv =====
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types and constants of the smudge brush engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sbe_pkg;

   localparam int MAX_RADIUS   = 16;
   localparam int MAX_WIDTH    = 256;
   localparam int MAX_HEIGHT   = 256;

   localparam int WIN_SIDE     = 2 * MAX_RADIUS + 1;
   localparam int PAINT_DEPTH  = WIN_SIDE * WIN_SIDE;
   localparam int CANVAS_DEPTH = MAX_WIDTH * MAX_HEIGHT;

   localparam int PA_W   = $clog2(PAINT_DEPTH);
   localparam int CA_W   = $clog2(CANVAS_DEPTH);
   localparam int WIN_W  = $clog2(WIN_SIDE);
   localparam int PX_W   = $clog2(MAX_WIDTH);
   localparam int PY_W   = $clog2(MAX_HEIGHT);

   // field and register widths
   localparam int ACT_W  = 2;
   localparam int POS_W  = 11;
   localparam int PIX_W  = 32;
   localparam int RAD_W  = 5;
   localparam int ALPHA_W = 8;
   localparam int DIM_W  = 9;
   localparam int CSR_W  = 9;
   localparam int IDX_W  = 2;

   // squared distance, square-root operand, offset and coordinate widths
   localparam int D_W    = 10;
   localparam int SQ_N_W = D_W + 32;
   localparam int SQ_R_W = SQ_N_W / 2;
   localparam int SUB_W  = SQ_R_W + 2;
   localparam int OFF_W  = WIN_W + 1;
   localparam int CRD_W  = POS_W + 2;

   localparam logic [RAD_W-1:0]   RADIUS_RESET = RAD_W'(4);
   localparam logic [ALPHA_W-1:0] ALPHA_RESET  = ALPHA_W'(255);
   localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(256);
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(256);

   typedef enum logic [IDX_W-1:0] {
      REG_RADIUS = 2'd0,
      REG_ALPHA  = 2'd1,
      REG_WIDTH  = 2'd2,
      REG_HEIGHT = 2'd3
   } reg_index_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_BRUSH = 2'd2,
      ACT_DRAG  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_EXEC,
      ST_RESP,
      ST_WIN,
      ST_D_READ,
      ST_SQRT,
      ST_DIV,
      ST_WEIGHT,
      ST_MASK,
      ST_BLEND,
      ST_D_WRITE,
      ST_P_READ,
      ST_P_WRITE
   } state_type;

endpackage : sbe_pkg

`default_nettype wire

// ===== rtl/smudge_brush_engine_unit.sv =====
// ----------------------------------------------------------------------------
// smudge_brush_engine_unit
// Smudge brush over an RGBA canvas with a square paint window.
// ----------------------------------------------------------------------------
// Usage: one request word on req_* (valid/stall) carries action, x_pos, y_pos
// and pixel_in. Only a read returns a word on rsp_* (pixel_out, zero when the
// pixel lies outside the canvas). Registers are written through csr_we,
// csr_index and csr_wdata; the user must do so only while the engine is
// idle, which the block does not enforce. A write or read word passes the
// decode and execute states; a read then waits in the response state while
// an earlier response is stalled. Brush down copies each in-canvas window
// pixel into the paint store. For each in-canvas pixel of nonzero weight a
// drag runs one shared compare-subtract unit through a 21-step square root
// and a 21-step divide by the radius, then repeats the brush-down sweep.
// After reset all 1089 paint store entries are cleared, one entry a cycle,
// with req_stall high; register writes are taken during that sweep.
// A stalled response is held in the output register; a later read waits
// until it has been taken. req_stall is low only while the engine is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module smudge_brush_engine_unit
   import sbe_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [ACT_W-1:0]   req_action,
   input  wire logic [POS_W-1:0]   req_x_pos,
   input  wire logic [POS_W-1:0]   req_y_pos,
   input  wire logic [PIX_W-1:0]   req_pixel_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [PIX_W-1:0]        rsp_pixel_out,
   input  wire logic               csr_we,
   input  wire logic [IDX_W-1:0]   csr_index,
   input  wire logic [CSR_W-1:0]   csr_wdata
);

   state_type state_ff, state_in;

   logic [RAD_W-1:0]   radius_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;

   logic [ACT_W-1:0]   act_ff;
   logic [POS_W-1:0]   x_ff;
   logic [POS_W-1:0]   y_ff;
   logic [PIX_W-1:0]   pix_ff;

   logic [WIN_W-1:0]   wi_ff;
   logic [WIN_W-1:0]   wj_ff;
   logic [PA_W-1:0]    pidx_ff;
   logic               drag_ph_ff;
   logic [4:0]         cnt_ff;
   logic [1:0]         ch_ff;

   logic [CA_W-1:0]    addr_ff;
   logic               inside_ff;
   logic [D_W-1:0]     d_ff;
   logic               wzero_ff;

   logic [SQ_N_W-1:0]  n_ff;
   logic [SQ_R_W-1:0]  root_ff;
   logic [SUB_W-1:0]   rem_ff;
   logic [15:0]        w_ff;
   logic [23:0]        m_ff;
   logic [23:0]        blend_ff;

   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_pixel_ff;

   logic [PIX_W-1:0]   canvas_mem [CANVAS_DEPTH];
   logic [PIX_W-1:0]   paint_mem  [PAINT_DEPTH];
   logic [PIX_W-1:0]   cv_rdata_ff;
   logic [PIX_W-1:0]   pr_rdata_ff;

   // effective register values
   logic [RAD_W-1:0]   rad_eff;
   logic [DIM_W-1:0]   w_eff;
   logic [DIM_W-1:0]   h_eff;
   logic [WIN_W-1:0]   side_last;

   // window / address calculation
   logic signed [OFF_W-1:0]   off_x, off_y;
   logic signed [CRD_W-1:0]   px, py;
   logic signed [2*OFF_W-1:0] sq_x, sq_y;
   logic [D_W-1:0]            d_calc;
   logic [D_W-1:0]            rr;
   logic                      pos_in;
   logic [PY_W+DIM_W-1:0]     addr_sum;
   logic                      win_last;

   // shared compare-subtract unit
   logic [SUB_W-1:0]  sub_a, sub_b;
   logic [SUB_W:0]    sub_diff;
   logic              sub_ge;

   // blend
   logic [7:0]               c_byte, p_byte;
   logic signed [8:0]        bdif;
   logic signed [33:0]       bsum;

   // strobes
   logic               cv_re, cv_we, pw_en, pr_en, win_step, rsp_load;
   logic [PIX_W-1:0]   cv_wdata, pw_data;
   logic               req_take;

   always_comb begin
      rad_eff = (radius_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_ff;
      if (width_ff == '0) w_eff = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = DIM_W'(1);
      else if (height_ff > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
      else h_eff = height_ff;
      side_last = {rad_eff, 1'b0};
   end

   // coordinate of the current pixel: request position, plus the window offset in the window state
   always_comb begin
      if (state_ff == ST_WIN) begin
         off_x = $signed({1'b0, wj_ff}) - $signed(OFF_W'(rad_eff));
         off_y = $signed({1'b0, wi_ff}) - $signed(OFF_W'(rad_eff));
      end else begin
         off_x = '0;
         off_y = '0;
      end
      px = $signed({{(CRD_W-POS_W){x_ff[POS_W-1]}}, x_ff})
         + $signed({{(CRD_W-OFF_W){off_x[OFF_W-1]}}, off_x});
      py = $signed({{(CRD_W-POS_W){y_ff[POS_W-1]}}, y_ff})
         + $signed({{(CRD_W-OFF_W){off_y[OFF_W-1]}}, off_y});
      pos_in = !px[CRD_W-1] && !py[CRD_W-1]
            && (px < $signed({{(CRD_W-DIM_W){1'b0}}, w_eff}))
            && (py < $signed({{(CRD_W-DIM_W){1'b0}}, h_eff}));
      addr_sum = py[PY_W-1:0] * w_eff
               + {{(PY_W+DIM_W-PX_W){1'b0}}, px[PX_W-1:0]};
      sq_x   = off_x * off_x;
      sq_y   = off_y * off_y;
      d_calc = sq_x[D_W-1:0] + sq_y[D_W-1:0];
      rr     = D_W'(rad_eff) * D_W'(rad_eff);
      win_last = (wi_ff == side_last) && (wj_ff == side_last);
   end

   // one compare-subtract serves both the square root and the divide
   always_comb begin
      if (state_ff == ST_SQRT) begin
         sub_a = {rem_ff[SQ_R_W-1:0], n_ff[SQ_N_W-1 -: 2]};
         sub_b = {1'b0, root_ff[SQ_R_W-2:0], 2'b01};
      end else begin
         sub_a = {{(SUB_W-RAD_W-1){1'b0}}, rem_ff[RAD_W-1:0], root_ff[SQ_R_W-1]};
         sub_b = {{(SUB_W-RAD_W){1'b0}}, rad_eff};
      end
      sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
      sub_ge   = !sub_diff[SUB_W];
   end

   // c*(2^24-m) + p*m rewritten as (c<<24) + (p-c)*m
   always_comb begin
      case (ch_ff)
         2'd0: begin
            c_byte = cv_rdata_ff[7:0];
            p_byte = pr_rdata_ff[7:0];
         end
         2'd1: begin
            c_byte = cv_rdata_ff[15:8];
            p_byte = pr_rdata_ff[15:8];
         end
         default: begin
            c_byte = cv_rdata_ff[23:16];
            p_byte = pr_rdata_ff[23:16];
         end
      endcase
      bdif = $signed({1'b0, p_byte}) - $signed({1'b0, c_byte});
      bsum = $signed({2'b00, c_byte, 24'h000000})
           + bdif * $signed({1'b0, m_ff})
           + 34'sh0800000;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (pidx_ff == PA_W'(PAINT_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE: if (req_valid) state_in = ST_DECODE;
         ST_DECODE: state_in = ST_EXEC;
         ST_EXEC: begin
            case (act_ff)
               ACT_WRITE: state_in = ST_IDLE;
               ACT_READ:  state_in = ST_RESP;
               default:   state_in = ST_WIN;
            endcase
         end
         ST_RESP: if (rsp_load) state_in = ST_IDLE;
         ST_D_READ: state_in = wzero_ff ? ST_MASK : ST_SQRT;
         ST_SQRT: if (cnt_ff == '0) state_in = ST_DIV;
         ST_DIV: if (cnt_ff == '0) state_in = ST_WEIGHT;
         ST_WEIGHT: state_in = ST_MASK;
         ST_MASK: state_in = ST_BLEND;
         ST_BLEND: if (ch_ff == 2'd2) state_in = ST_D_WRITE;
         ST_P_READ: state_in = ST_P_WRITE;
         ST_WIN, ST_D_WRITE, ST_P_WRITE: begin
            if (state_ff == ST_WIN && pos_in) begin
               state_in = drag_ph_ff ? ST_D_READ : ST_P_READ;
            end else if (!win_last || drag_ph_ff) begin
               state_in = ST_WIN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // strobes
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      cv_re     = (state_ff == ST_EXEC && act_ff == ACT_READ && inside_ff)
               || state_ff == ST_D_READ || state_ff == ST_P_READ;
      cv_we     = (state_ff == ST_EXEC && act_ff == ACT_WRITE && inside_ff)
               || state_ff == ST_D_WRITE;
      cv_wdata  = (state_ff == ST_D_WRITE) ? {8'hFF, blend_ff} : pix_ff;
      pw_en     = (state_ff == ST_CLEAR) || (state_ff == ST_P_WRITE);
      pw_data   = (state_ff == ST_CLEAR) ? '0 : cv_rdata_ff;
      pr_en     = (state_ff == ST_D_READ);
      win_step  = (state_ff == ST_WIN && !pos_in)
               || state_ff == ST_D_WRITE || state_ff == ST_P_WRITE;
      rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);
      req_take  = req_valid && !req_stall;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= RADIUS_RESET;
         alpha_ff     <= ALPHA_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_RADIUS: radius_ff <= csr_wdata[RAD_W-1:0];
               REG_ALPHA:  alpha_ff  <= csr_wdata[ALPHA_W-1:0];
               REG_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
               REG_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_CLEAR || (win_step && !win_last)) begin
            pidx_ff <= pidx_ff + PA_W'(1);
         end else if (state_ff == ST_EXEC || win_step) begin
            pidx_ff <= '0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_take) begin
         act_ff <= req_action;
         x_ff   <= req_x_pos;
         y_ff   <= req_y_pos;
         pix_ff <= req_pixel_in;
      end
      if (rsp_load) rsp_pixel_ff <= inside_ff ? cv_rdata_ff : '0;

      if (state_ff == ST_DECODE || state_ff == ST_WIN) begin
         addr_ff   <= addr_sum[CA_W-1:0];
         inside_ff <= pos_in;
         d_ff      <= d_calc;
         wzero_ff  <= (rad_eff == '0) || (d_calc >= rr);
      end

      if (state_ff == ST_EXEC) begin
         wi_ff      <= '0;
         wj_ff      <= '0;
         drag_ph_ff <= (act_ff == ACT_DRAG);
      end else if (win_step) begin
         if (win_last) begin
            wi_ff      <= '0;
            wj_ff      <= '0;
            drag_ph_ff <= 1'b0;
         end else if (wj_ff == side_last) begin
            wj_ff <= '0;
            wi_ff <= wi_ff + WIN_W'(1);
         end else begin
            wj_ff <= wj_ff + WIN_W'(1);
         end
      end

      case (state_ff)
         ST_D_READ: begin
            n_ff    <= {d_ff, 32'h0};
            root_ff <= '0;
            rem_ff  <= '0;
            cnt_ff  <= 5'(SQ_R_W - 1);
            w_ff    <= '0;
         end
         ST_SQRT: begin
            n_ff    <= {n_ff[SQ_N_W-3:0], 2'b00};
            root_ff <= {root_ff[SQ_R_W-2:0], sub_ge};
            // start the divide from a clean remainder
            if (cnt_ff == '0) begin
               rem_ff <= '0;
               cnt_ff <= 5'(SQ_R_W - 1);
            end else begin
               rem_ff <= sub_ge ? sub_diff[SUB_W-1:0] : sub_a;
               cnt_ff <= cnt_ff - 5'd1;
            end
         end
         ST_DIV: begin
            root_ff <= {root_ff[SQ_R_W-2:0], sub_ge};
            rem_ff  <= sub_ge ? sub_diff[SUB_W-1:0] : sub_a;
            cnt_ff  <= cnt_ff - 5'd1;
         end
         ST_WEIGHT: begin
            // 65536 - q, held at 65535 when q is zero
            w_ff <= (root_ff[15:0] == '0) ? 16'hFFFF : (16'h0000 - root_ff[15:0]);
         end
         ST_MASK: begin
            m_ff  <= w_ff * alpha_ff;
            ch_ff <= 2'd0;
         end
         ST_BLEND: begin
            case (ch_ff)
               2'd0: blend_ff[7:0]   <= bsum[31:24];
               2'd1: blend_ff[15:8]  <= bsum[31:24];
               default: blend_ff[23:16] <= bsum[31:24];
            endcase
            ch_ff <= ch_ff + 2'd1;
         end
         default: ;
      endcase
   end

   // canvas store
   always_ff @(posedge clock) begin
      if (cv_we) canvas_mem[addr_ff] <= cv_wdata;
      if (cv_re) cv_rdata_ff <= canvas_mem[addr_ff];
   end

   // paint store
   always_ff @(posedge clock) begin
      if (pw_en) paint_mem[pidx_ff] <= pw_data;
      if (pr_en) pr_rdata_ff <= paint_mem[pidx_ff];
   end

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(cv_we && cv_re))
      else $error("canvas read and write in one cycle");

   a_sqrt_to_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT && cnt_ff == '0) |=> (state_ff == ST_DIV))
      else $error("square root did not hand over to divide");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESP))
      else $error("response word raised outside read completion");

   a_paint_idx: assert property (@(posedge clock) disable iff (reset)
      pw_en |-> (pidx_ff < PA_W'(PAINT_DEPTH)))
      else $error("paint index beyond store");

endmodule : smudge_brush_engine_unit

`default_nettype wire
